FILE: hw/rtl/tpid_pkg.sv
// ----------------------------------------------------------------------------
// Trace packet IP decoder package
// Shared constants, packet codes, payload and control types, and the address
// sign extension used by the decoder.
// ----------------------------------------------------------------------------
package tpid_pkg;

  localparam int unsigned WINDOW_BYTES = 16;
  localparam int unsigned ADDRESS_BITS = 48;
  localparam int unsigned PSB_LEN      = 16;
  localparam int unsigned MAX_RESULTS  = 6;

  localparam int unsigned CNT_W  = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned IDX_W  = $clog2(WINDOW_BYTES);
  localparam int unsigned NRES_W = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] HDR_EXT     = 8'h02;
  localparam logic [7:0] EXT_LTNT    = 8'ha3;
  localparam logic [7:0] EXT_CBR     = 8'h03;
  localparam logic [7:0] EXT_STOP    = 8'h83;
  localparam logic [7:0] EXT_PSBEND  = 8'h23;
  localparam logic [7:0] EXT_PSB     = 8'h82;
  localparam logic [7:0] HDR_MODE    = 8'h99;
  localparam logic [4:0] IP_TIP      = 5'h0d;
  localparam logic [4:0] IP_TIP_PGE  = 5'h11;
  localparam logic [4:0] IP_TIP_PGD  = 5'h01;
  localparam logic [4:0] IP_FUP      = 5'h1d;

  typedef struct packed {
    logic [7:0] trace_byte;
    logic       end_of_buffer;
  } tpid_in_t;

  typedef struct packed {
    logic [63:0] target_ip;
    logic        final_res;
  } tpid_out_t;

  typedef logic [WINDOW_BYTES-1:0][7:0] tpid_win_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT,
    ST_PUSH,
    ST_FINISH
  } tpid_state_e;

  typedef struct packed {
    logic take;
    logic apply;
    logic flush;
    logic shift;
    logic pend_new;
    logic pend_addr;
    logic pend_clr;
    logic out_valid;
    logic out_final;
  } tpid_cmd_t;

  typedef struct packed {
    logic go;
    logic cut;
    logic bypass;
    logic emit_ok;
    logic pend_v;
    logic shift_last;
    logic shl_zero;
  } tpid_status_t;

  function automatic logic [63:0] sext_addr(input logic [63:0] v);
    logic [63:0] m;
    m = '1;
    if (ADDRESS_BITS < 64) begin
      m = (64'd1 << ADDRESS_BITS) - 64'd1;
    end
    if (v[ADDRESS_BITS-1]) begin
      return v | ~m;
    end
    return v & m;
  endfunction

endpackage

FILE: hw/rtl/trace_packet_ip_decoder.sv
// ----------------------------------------------------------------------------
// Trace packet IP decoder
// Takes processor-trace bytes one transaction at a time and returns the
// reconstructed target IP of every TIP packet whose IP length field is one to three.
// ----------------------------------------------------------------------------
// Each input transaction carries one trace byte and an end-of-buffer flag.
// Bytes fill a 16-byte lookahead window; once it is full, or when the flag is
// set, packets are decoded from its front and removed from the window.
// Each such TIP packet yields one output transaction with the updated IP; the last
// output transaction caused by an input byte has final_res set. An input byte
// that causes no result yields no output transaction.
// After a byte is taken, packets are decoded one at a time, and the bytes of
// each are shifted out of the window, which shifts by one byte a cycle; a
// packet that empties the window is removed without shifting. Each result
// is delivered from an output state that holds until the receiver takes it.
// The next byte is taken only when all results of the current one have been
// delivered; a stalled receiver holds the block with the result unchanged.
// Reset empties the window and clears the last IP to zero.
// ----------------------------------------------------------------------------
module trace_packet_ip_decoder
  import tpid_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tpid_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tpid_out_t out_data_o
);

  tpid_cmd_t    cmd;
  tpid_status_t status;

  tpid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tpid_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

  assign out_valid_o = cmd.out_valid;

endmodule

FILE: hw/rtl/tpid_decode.sv
// ----------------------------------------------------------------------------
// Trace packet decoder
// Classifies the packet at the front of the window and works out how many
// bytes it occupies and how it changes the last IP.
// ----------------------------------------------------------------------------
module tpid_decode
  import tpid_pkg::*;
(
  input  tpid_win_t         win_i,
  input  logic [CNT_W-1:0]  cnt_i,
  input  logic [63:0]       addr_i,
  output logic [CNT_W-1:0]  used_o,
  output logic              emit_o,
  output logic              addr_we_o,
  output logic [63:0]       addr_o
);

  logic [7:0]       b0;
  logic [7:0]       b1;
  logic [4:0]       low;
  logic [2:0]       ipl;
  logic [CNT_W-1:0] need;
  logic             is_ext;
  logic             is_ip;
  logic             psb_match;
  logic [63:0]      v;

  assign b0     = win_i[0];
  assign b1     = win_i[1];
  assign low    = b0[4:0];
  assign ipl    = b0[7:5];
  assign need   = CNT_W'(1) + CNT_W'({ipl, 1'b0});
  assign is_ext = (b0 == HDR_EXT);
  assign is_ip  = b0[0] && (low == IP_TIP || low == IP_TIP_PGE ||
                            low == IP_TIP_PGD || low == IP_FUP);

  always_comb begin
    psb_match = 1'b1;
    for (int i = 0; i < PSB_LEN; i++) begin
      if (CNT_W'(i) < cnt_i &&
          win_i[i] != (((i % 2) == 1) ? EXT_PSB : HDR_EXT)) begin
        psb_match = 1'b0;
      end
    end
  end

  always_comb begin
    v = addr_i;
    for (int i = 0; i < 3; i++) begin
      if (3'(i) < ipl) begin
        v[16*i +: 16] = {win_i[2 + 2*i], win_i[1 + 2*i]};
      end
    end
    v = sext_addr(v);
  end

  always_comb begin
    used_o    = '0;
    emit_o    = 1'b0;
    addr_we_o = 1'b0;
    addr_o    = v;
    priority if (is_ext && cnt_i < CNT_W'(2)) begin
      used_o = '0;
    end else if (is_ext && b1 == EXT_LTNT) begin
      used_o = (cnt_i >= CNT_W'(8)) ? CNT_W'(8) : '0;
    end else if (is_ext && b1 == EXT_CBR && cnt_i < CNT_W'(4)) begin
      used_o = '0;
    end else if (is_ext && b1 == EXT_CBR && win_i[3] == 8'h00) begin
      used_o = CNT_W'(4);
    end else if (is_ext && (b1 == EXT_STOP || b1 == EXT_PSBEND)) begin
      used_o = CNT_W'(2);
    end else if (is_ext && b1 == EXT_PSB && psb_match) begin
      used_o = (cnt_i >= CNT_W'(PSB_LEN)) ? CNT_W'(PSB_LEN) : '0;
    end else if (!b0[0]) begin
      used_o = CNT_W'(1);
    end else if (is_ip && ipl == 3'd0) begin
      used_o    = CNT_W'(1);
      addr_we_o = 1'b1;
      addr_o    = '0;
    end else if (is_ip && ipl >= 3'd4) begin
      used_o = CNT_W'(1);
    end else if (is_ip && cnt_i < need) begin
      used_o = '0;
    end else if (is_ip) begin
      used_o    = need;
      addr_we_o = 1'b1;
      emit_o    = (low == IP_TIP);
    end else if (b0 == HDR_MODE && cnt_i < CNT_W'(2)) begin
      used_o = '0;
    end else if (b0 == HDR_MODE && b1[7:5] <= 3'd1) begin
      used_o = CNT_W'(2);
    end else begin
      used_o = CNT_W'(1);
    end
  end

endmodule

FILE: hw/rtl/tpid_datapath.sv
// ----------------------------------------------------------------------------
// Trace packet decoder datapath
// Holds the lookahead window, fill count, last IP and the pending result, and
// carries out the commands of the controller.
// ----------------------------------------------------------------------------
module tpid_datapath
  import tpid_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tpid_in_t     in_data_i,
  input  tpid_cmd_t    cmd_i,
  output tpid_status_t status_o,
  output tpid_out_t    out_data_o
);

  tpid_win_t          win_q, win_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   shl_q, shl_d;
  logic [NRES_W-1:0]  nres_q, nres_d;
  logic [63:0]        addr_q, addr_d;
  logic [63:0]        pend_ip_q, pend_ip_d;
  logic               pend_v_q, pend_v_d;
  logic               drain_q, drain_d;

  logic [CNT_W-1:0]   used;
  logic               emit;
  logic               addr_we;
  logic [63:0]        addr_new;
  logic               emit_ok;

  tpid_decode u_decode (
    .win_i     (win_q),
    .cnt_i     (cnt_q),
    .addr_i    (addr_q),
    .used_o    (used),
    .emit_o    (emit),
    .addr_we_o (addr_we),
    .addr_o    (addr_new)
  );

  assign emit_ok = emit && (nres_q < NRES_W'(MAX_RESULTS));

  assign status_o.go         = (cnt_q != '0) && (drain_q || cnt_q >= CNT_W'(WINDOW_BYTES));
  assign status_o.cut        = (used == '0);
  assign status_o.bypass     = (used >= cnt_q);
  assign status_o.emit_ok    = emit_ok;
  assign status_o.pend_v     = pend_v_q;
  assign status_o.shift_last = (shl_q == CNT_W'(1));
  assign status_o.shl_zero   = (shl_q == '0);

  assign out_data_o.target_ip = pend_ip_q;
  assign out_data_o.final_res = cmd_i.out_final;

  always_comb begin
    win_d     = win_q;
    cnt_d     = cnt_q;
    shl_d     = shl_q;
    nres_d    = nres_q;
    addr_d    = addr_q;
    pend_ip_d = pend_ip_q;
    pend_v_d  = pend_v_q;
    drain_d   = drain_q;
    if (cmd_i.take) begin
      if (cnt_q < CNT_W'(WINDOW_BYTES)) begin
        win_d[cnt_q[IDX_W-1:0]] = in_data_i.trace_byte;
        cnt_d = cnt_q + CNT_W'(1);
      end
      drain_d = in_data_i.end_of_buffer;
      nres_d  = '0;
    end
    if (cmd_i.flush) begin
      cnt_d = '0;
    end
    if (cmd_i.apply) begin
      if (addr_we) begin
        addr_d = addr_new;
      end
      if (used >= cnt_q) begin
        cnt_d = '0;
        shl_d = '0;
      end else begin
        shl_d = used;
      end
      if (emit_ok) begin
        nres_d = nres_q + NRES_W'(1);
      end
    end
    if (cmd_i.shift) begin
      for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      cnt_d = cnt_q - CNT_W'(1);
      shl_d = shl_q - CNT_W'(1);
    end
    if (cmd_i.pend_new) begin
      pend_ip_d = addr_new;
      pend_v_d  = 1'b1;
    end
    if (cmd_i.pend_addr) begin
      pend_ip_d = addr_q;
      pend_v_d  = 1'b1;
    end
    if (cmd_i.pend_clr) begin
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      shl_q    <= '0;
      nres_q   <= '0;
      addr_q   <= '0;
      pend_v_q <= 1'b0;
      drain_q  <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      shl_q    <= shl_d;
      nres_q   <= nres_d;
      addr_q   <= addr_d;
      pend_v_q <= pend_v_d;
      drain_q  <= drain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q     <= win_d;
    pend_ip_q <= pend_ip_d;
  end

endmodule

FILE: hw/rtl/tpid_ctrl.sv
// ----------------------------------------------------------------------------
// Trace packet decoder controller
// Sequences byte intake, packet decoding, byte consumption and the delivery
// of results, driving the datapath through a command structure.
// ----------------------------------------------------------------------------
module tpid_ctrl
  import tpid_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         out_ready_i,
  input  tpid_status_t status_i,
  output tpid_cmd_t    cmd_o
);

  tpid_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!status_i.go || status_i.cut) begin
          cmd_o.flush = status_i.go;
          state_d     = status_i.pend_v ? ST_FINISH : ST_IDLE;
        end else begin
          cmd_o.apply = 1'b1;
          if (status_i.emit_ok && status_i.pend_v) begin
            state_d = ST_PUSH;
          end else begin
            cmd_o.pend_new = status_i.emit_ok;
            state_d        = status_i.bypass ? ST_DECODE : ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (status_i.shift_last) begin
          state_d = ST_DECODE;
        end
      end
      ST_PUSH: begin
        cmd_o.out_valid = 1'b1;
        if (out_ready_i) begin
          cmd_o.pend_addr = 1'b1;
          state_d         = status_i.shl_zero ? ST_DECODE : ST_SHIFT;
        end
      end
      ST_FINISH: begin
        cmd_o.out_valid = 1'b1;
        cmd_o.out_final = 1'b1;
        if (out_ready_i) begin
          cmd_o.pend_clr = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
